FILE: rtl/e2c_pkg.sv
package e2c_pkg;

  localparam int unsigned FirstYear = 70;
  localparam logic [7:0]  Year2100Idx = 8'd130;
  localparam logic [2:0]  EpochWeekday = 3'd4;

  // reciprocal constants, rounded up; exact over the operand ranges used
  localparam logic [25:0] DayRecip  = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
  localparam int unsigned DayShift  = 35;
  localparam logic [16:0] YearRecip = 17'(((64'd1 << 25) + 64'd364) / 64'd365);
  localparam int unsigned YearShift = 25;
  localparam logic [17:0] HourRecip = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam int unsigned HourShift = 29;
  localparam logic [12:0] MinRecip  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam int unsigned MinShift  = 18;

  localparam logic [8:0] MonthStartLeap [13] =
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274,
      9'd305, 9'd335, 9'd366};
  localparam logic [8:0] MonthStartCommon [13] =
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
      9'd304, 9'd334, 9'd365};

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] v;
    v = leap ? MonthStartLeap[m] : MonthStartCommon[m];
    return v;
  endfunction

  // days from the epoch to January 1 of year index yi (years after 1970)
  function automatic logic [15:0] jan1_days(input logic [7:0] yi);
    logic [8:0]  yp1;
    logic [15:0] base;
    logic [15:0] leaps;
    yp1   = {1'b0, yi} + 9'd1;
    base  = 16'(yi) * 16'd365;
    leaps = 16'(yp1[8:2]) - ((yi > Year2100Idx) ? 16'd1 : 16'd0);
    return base + leaps;
  endfunction

endpackage

FILE: rtl/e2c_stamp_if.sv
interface e2c_stamp_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source(output valid, epoch_seconds, input ready);
  modport sink(input valid, epoch_seconds, output ready);
endinterface

FILE: rtl/e2c_cal_if.sv
interface e2c_cal_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_since_1900;
  logic [3:0] month_index;
  logic [4:0] day_of_month;
  logic [8:0] day_of_year;
  logic [2:0] weekday;
  logic [4:0] hour_of_day;
  logic [5:0] minute_of_hour;
  logic [5:0] second_of_minute;

  modport source(output valid, year_since_1900, month_index, day_of_month, day_of_year,
                 weekday, hour_of_day, minute_of_hour, second_of_minute, input ready);
  modport sink(input valid, year_since_1900, month_index, day_of_month, day_of_year,
               weekday, hour_of_day, minute_of_hour, second_of_minute, output ready);
endinterface

FILE: rtl/e2c_tod.sv
// seconds of day -> hour, minute, second; four register stages
module e2c_tod
  import e2c_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] rem,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic [16:0] rem3;
  logic [34:0] hprod3;
  logic [4:0]  h_est;
  logic [16:0] h3600;
  logic [4:0]  h4;
  logic [11:0] r2_4;
  logic [4:0]  h5;
  logic [11:0] r2_5;
  logic [24:0] mprod5;
  logic [5:0]  m_est;
  logic [11:0] m60;

  assign h_est = hprod3[HourShift+4:HourShift];
  assign h3600 = 17'(h_est) * 17'd3600;
  assign m_est = mprod5[MinShift+5:MinShift];
  assign m60   = 12'(m_est) * 12'd60;

  always_ff @(posedge clk) begin
    if (en) begin
      rem3   <= rem;
      hprod3 <= 35'(rem) * 35'(HourRecip);
      h4     <= h_est;
      r2_4   <= rem3[11:0] - h3600[11:0];
      h5     <= h4;
      r2_5   <= r2_4;
      mprod5 <= 25'(r2_4) * 25'(MinRecip);
      hour   <= h5;
      minute <= m_est;
      second <= r2_5[5:0] - m60[5:0];
    end
  end

endmodule

FILE: rtl/epoch_seconds_to_calendar_core.sv
// channel   dir  modport  payload
// stamp     in   sink     epoch_seconds[31:0]
// calendar  out  source   year, month, mday, yday, wday, hour, minute, second
//
// Six register stages, last one is the output register.
// One transaction per cycle while calendar is not stalled; each stage holds
// constant-reciprocal multiplies and/or subtract/compare steps.
// rst (synchronous) clears the stage valid bits only.
// A stall on calendar freezes every stage; stamp.ready follows it.
module epoch_seconds_to_calendar_core
  import e2c_pkg::*;
(
  input  logic clk,
  input  logic rst,
  e2c_stamp_if.sink  stamp,
  e2c_cal_if.source  calendar
);

  logic [5:0]  vld;
  logic        en;

  // stage 1
  logic [31:0] secs1;
  logic [50:0] dprod1;
  // stage 2
  logic [15:0] days_c;
  logic [25:0] d675;
  logic [16:0] wsum_in;
  logic [5:0]  wsum;
  logic [3:0]  wfold;
  logic [2:0]  wday_c;
  logic [15:0] days2;
  logic [16:0] rem2;
  logic [32:0] yprod2;
  logic [2:0]  wday2;
  // stage 3
  logic [7:0]  ye_c;
  logic [7:0]  ye_m1;
  logic [15:0] days3;
  logic [7:0]  ye3;
  logic [15:0] jan_a3;
  logic [15:0] jan_b3;
  logic [2:0]  wday3;
  // stage 4
  logic        back_c;
  logic [15:0] yd_full;
  logic [7:0]  yi_c;
  logic [7:0]  yi4;
  logic [8:0]  yday4;
  logic        leap4;
  logic [2:0]  wday4;
  // stage 5
  logic [3:0]  mon_c;
  logic [7:0]  yi5;
  logic [8:0]  yday5;
  logic        leap5;
  logic [3:0]  mon5;
  logic [2:0]  wday5;
  // stage 6
  logic [8:0]  mstart;
  logic [8:0]  dom_full;
  logic [7:0]  year6;
  logic [3:0]  mon6;
  logic [4:0]  dom6;
  logic [8:0]  yday6;
  logic [2:0]  wday6;
  logic [4:0]  hour6;
  logic [5:0]  min6;
  logic [5:0]  sec6;

  assign en          = !vld[5] || calendar.ready;
  assign stamp.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], stamp.valid};
    end
  end

  // days since epoch and seconds of day
  assign days_c  = dprod1[DayShift+15:DayShift];
  assign d675    = 26'(days_c) * 26'd675;
  // (days + 4) mod 7 by octal digit folding
  assign wsum_in = 17'(days_c) + 17'(EpochWeekday);
  assign wsum    = 6'(wsum_in[2:0]) + 6'(wsum_in[5:3]) + 6'(wsum_in[8:6])
                 + 6'(wsum_in[11:9]) + 6'(wsum_in[14:12]) + 6'(wsum_in[16:15]);
  assign wfold   = 4'(wsum[5:3]) + 4'(wsum[2:0]);
  assign wday_c  = (wfold >= 4'd7) ? 3'(wfold - 4'd7) : wfold[2:0];

  // year estimate and the two candidate year starts
  assign ye_c  = yprod2[YearShift+7:YearShift];
  assign ye_m1 = (ye_c == 8'd0) ? 8'd0 : ye_c - 8'd1;

  // estimate overshoots by at most one year
  assign back_c  = days3 < jan_a3;
  assign yi_c    = back_c ? ye3 - 8'd1 : ye3;
  assign yd_full = days3 - (back_c ? jan_b3 : jan_a3);

  always_comb begin
    mon_c = '0;
    for (int k = 1; k < 12; k++) begin
      if (yday4 >= month_start(leap4, 4'(k))) mon_c = mon_c + 4'd1;
    end
  end

  assign mstart   = month_start(leap5, mon5);
  assign dom_full = yday5 - mstart + 9'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      secs1  <= stamp.epoch_seconds;
      dprod1 <= 51'(stamp.epoch_seconds[31:7]) * 51'(DayRecip);

      days2  <= days_c;
      rem2   <= {secs1[16:7] - d675[9:0], secs1[6:0]};
      yprod2 <= 33'(days_c) * 33'(YearRecip);
      wday2  <= wday_c;

      days3  <= days2;
      ye3    <= ye_c;
      jan_a3 <= jan1_days(ye_c);
      jan_b3 <= jan1_days(ye_m1);
      wday3  <= wday2;

      yi4    <= yi_c;
      yday4  <= yd_full[8:0];
      leap4  <= (yi_c[1:0] == 2'd2) && (yi_c != Year2100Idx);
      wday4  <= wday3;

      yi5    <= yi4;
      yday5  <= yday4;
      leap5  <= leap4;
      mon5   <= mon_c;
      wday5  <= wday4;

      year6  <= yi5 + 8'(FirstYear);
      mon6   <= mon5;
      dom6   <= dom_full[4:0];
      yday6  <= yday5;
      wday6  <= wday5;
    end
  end

  e2c_tod u_tod (
    .clk    (clk),
    .en     (en),
    .rem    (rem2),
    .hour   (hour6),
    .minute (min6),
    .second (sec6)
  );

  assign calendar.valid            = vld[5];
  assign calendar.year_since_1900  = year6;
  assign calendar.month_index      = mon6;
  assign calendar.day_of_month     = dom6;
  assign calendar.day_of_year      = yday6;
  assign calendar.weekday          = wday6;
  assign calendar.hour_of_day      = hour6;
  assign calendar.minute_of_hour   = min6;
  assign calendar.second_of_minute = sec6;

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (mon6 <= 4'd11 && dom6 != 5'd0 && year6 >= 8'd70 && year6 <= 8'd206))
    else $error("calendar date field out of range");

  a_yday_wday: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (yday6 <= 9'd365 && wday6 <= 3'd6))
    else $error("day of year or weekday out of range");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (hour6 <= 5'd23 && min6 <= 6'd59 && sec6 <= 6'd59))
    else $error("time of day out of range");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (stamp.valid && stamp.ready) |=> vld[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule
